FILE: hdl/sgr_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants of the stream group reverser.
// -----------------------------------------------------------------------------
package sgr_pkg;

   localparam int MAX_GROUP_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int GROUP_W        = 5;

   localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(1);

   // per-chain control for one cycle
   typedef struct packed {
      logic push;   // shift up, new item enters at cell 0
      logic load;   // write the new item at the addressed cell
      logic pop;    // shift down toward cell 0
   } sgr_ctrl_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } sgr_state_type;

endpackage : sgr_pkg
`default_nettype wire

FILE: hdl/sgr_cell.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sgr_cell
// One storage cell of the chain; takes data from either neighbor or the input.
// -----------------------------------------------------------------------------
module sgr_cell
   import sgr_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire sgr_ctrl_type     ctrl,
   input  wire logic             sel,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic [WIDTH-1:0] from_lower,
   input  wire logic [WIDTH-1:0] from_upper,
   output logic      [WIDTH-1:0] q
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load && sel) begin
         data_in = din;
      end else if (ctrl.push) begin
         data_in = from_lower;
      end else if (ctrl.pop) begin
         data_in = from_upper;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule : sgr_cell
`default_nettype wire

FILE: hdl/sgr_chain.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sgr_chain
// Row of cells working as a stack (push/pop) or a queue (load/pop).
// -----------------------------------------------------------------------------
module sgr_chain
   import sgr_pkg::*;
#(
   parameter int DEPTH = MAX_GROUP_DEF,
   parameter int WIDTH = DATA_WIDTH_DEF,
   parameter int IDX_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire sgr_ctrl_type     ctrl,
   input  wire logic [IDX_W-1:0] load_index,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] head
);

   logic [WIDTH-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] lower;
      logic [WIDTH-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = din;
      end else begin : g_mid
         assign lower = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper = '0;
      end else begin : g_below
         assign upper = cell_q[i+1];
      end

      sgr_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sel        (load_index == IDX_W'(i)),
         .din        (din),
         .from_lower (lower),
         .from_upper (upper),
         .q          (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule : sgr_chain
`default_nettype wire

FILE: hdl/stream_group_reverser_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// stream_group_reverser_unit
// Reverse a stream of values in groups of group_size; a partial group at the
// end of the list leaves in arrival order.
// Output: the first result of a group is registered after the block has
//   entered drain on the item that completes the group (or ends the list);
//   then one per cycle while the output is not stalled. Throughput: one
//   item per cycle while filling; the input stalls while a group drains.
// Reset: synchronous; clears fill count, drain state, output valid and sets
//   group_size to 1. Cell contents are not reset.
// -----------------------------------------------------------------------------
module stream_group_reverser_unit
   import sgr_pkg::*;
#(
   parameter int MAX_GROUP  = MAX_GROUP_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration
   input  wire logic                      csr_write_enable,
   input  wire logic [GROUP_W-1:0]        csr_write_data,
   // input items
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_end_of_list,
   // result items
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_out_value,
   output logic                           rsp_run_last,
   output logic                           rsp_list_done
);

   localparam int CW = $clog2(MAX_GROUP + 1);          // count width
   localparam int GW = (CW > GROUP_W) ? CW : GROUP_W;  // compare width

   // --- registers ---
   sgr_state_type            state_ff,   state_in;
   logic [CW-1:0]            fill_ff,    fill_in;
   logic [CW-1:0]            remain_ff,  remain_in;
   logic                     reverse_ff, reverse_in;
   logic                     eol_ff,     eol_in;
   logic [GROUP_W-1:0]       group_ff,   group_in;
   logic                     valid_ff,   valid_in;
   logic [VALUE_W-1:0]       value_ff,   value_in;
   logic                     last_ff,    last_in;
   logic                     done_ff,    done_in;

   // --- datapath ---
   logic                     accept;
   logic                     out_free;
   logic                     pop;
   logic [CW-1:0]            n_next;
   logic [GW-1:0]            group_ext;
   logic [GW-1:0]            eff_group;
   logic                     group_full;
   logic [DATA_WIDTH-1:0]    din;
   logic [DATA_WIDTH-1:0]    stack_head;
   logic [DATA_WIDTH-1:0]    queue_head;
   sgr_ctrl_type             stack_ctrl;
   sgr_ctrl_type             queue_ctrl;

   assign req_stall = (state_ff != ST_FILL);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_DRAIN) && out_free;

   // Fill never reaches MAX_GROUP while filling, so the count cannot wrap.
   assign n_next = fill_ff + CW'(1);
   assign din    = DATA_WIDTH'(req_value);

   // Zero acts as 1; anything above MAX_GROUP saturates.
   assign group_ext = GW'(group_ff);
   always_comb begin
      if (group_ext == '0) begin
         eff_group = GW'(1);
      end else if (group_ext > GW'(MAX_GROUP)) begin
         eff_group = GW'(MAX_GROUP);
      end else begin
         eff_group = group_ext;
      end
   end
   assign group_full = (GW'(n_next) >= eff_group);

   // The stack chain holds the newest item at its head (reverse order), the
   // queue chain the oldest (arrival order). Both take every item.
   always_comb begin
      stack_ctrl      = '0;
      stack_ctrl.push = accept;
      stack_ctrl.pop  = pop && reverse_ff;
      queue_ctrl      = '0;
      queue_ctrl.load = accept;
      queue_ctrl.pop  = pop && !reverse_ff;
   end

   sgr_chain #(
      .DEPTH (MAX_GROUP),
      .WIDTH (DATA_WIDTH),
      .IDX_W (CW)
   ) u_stack (
      .clock      (clock),
      .ctrl       (stack_ctrl),
      .load_index (fill_ff),
      .din        (din),
      .head       (stack_head)
   );

   sgr_chain #(
      .DEPTH (MAX_GROUP),
      .WIDTH (DATA_WIDTH),
      .IDX_W (CW)
   ) u_queue (
      .clock      (clock),
      .ctrl       (queue_ctrl),
      .load_index (fill_ff),
      .din        (din),
      .head       (queue_head)
   );

   // --- control ---
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      remain_in  = remain_ff;
      reverse_in = reverse_ff;
      eol_in     = eol_ff;
      group_in   = group_ff;
      valid_in   = valid_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      done_in    = done_ff;

      if (csr_write_enable) begin
         group_in = csr_write_data;
      end

      // Release the output register once the held item is taken.
      if (out_free) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (group_full || req_end_of_list) begin
                  // Drain: a full group reverses, a short final group does not.
                  state_in   = ST_DRAIN;
                  fill_in    = '0;
                  remain_in  = n_next;
                  reverse_in = group_full;
                  eol_in     = req_end_of_list;
               end else begin
                  fill_in = n_next;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               valid_in  = 1'b1;
               value_in  = VALUE_W'(reverse_ff ? stack_head : queue_head);
               last_in   = (remain_ff == CW'(1));
               done_in   = (remain_ff == CW'(1)) && eol_ff;
               remain_in = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FILL;
         fill_ff   <= '0;
         remain_ff <= '0;
         group_ff  <= GROUP_RESET;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         remain_ff <= remain_in;
         group_ff  <= group_in;
         valid_ff  <= valid_in;
      end
   end

   // Payload and drain mode; no reset needed.
   always_ff @(posedge clock) begin
      reverse_ff <= reverse_in;
      eol_ff     <= eol_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_value = value_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_list_done = done_ff;

   // --- assertions ---
   a_drain_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (remain_ff != '0))
      else $error("drain state with nothing left to send");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (fill_ff < CW'(MAX_GROUP)))
      else $error("fill count reached chain depth");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("list_done without run_last");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && (remain_ff == CW'(1))) |=> (state_ff == ST_FILL))
      else $error("drain did not end after last item");

endmodule : stream_group_reverser_unit
`default_nettype wire

FILE: sim/sgr_checker.sv
// -----------------------------------------------------------------------------
// sgr_checker
// Passive checker for the stream group reverser: tracks group_size writes and
// accepted input items, predicts the reordered results and compares each one
// accepted on the result channel against the oldest prediction.
// -----------------------------------------------------------------------------
module sgr_checker
   import sgr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [GROUP_W-1:0]        csr_write_data,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_end_of_list,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic signed [VALUE_W-1:0] rsp_out_value,
   input  wire logic                      rsp_run_last,
   input  wire logic                      rsp_list_done,
   output int                             fail_count,
   output int                             pending_count
);

   typedef struct {
      logic signed [VALUE_W-1:0] out_value;
      logic                      run_last;
      logic                      list_done;
   } reordered_item_type;

   reordered_item_type        reordered_q[$];
   logic [GROUP_W-1:0]        group_size_reg;
   logic signed [VALUE_W-1:0] group_store [MAX_GROUP_DEF];
   int                        fill_level;
   int                        errors;

   // zero acts as one, oversize saturates at the buffer depth
   function automatic int active_group_size();
      int g;
      g = int'(group_size_reg);
      if (g == 0) begin
         g = 1;
      end
      if (g > MAX_GROUP_DEF) begin
         g = MAX_GROUP_DEF;
      end
      return g;
   endfunction

   task automatic reorder_item(input logic signed [VALUE_W-1:0] value, input logic eol);
      int                 g;
      int                 n;
      reordered_item_type r;
      g = active_group_size();
      if (fill_level >= MAX_GROUP_DEF) begin
         fill_level = 0;
      end
      group_store[fill_level] = value;
      fill_level++;
      n = fill_level;
      // full group leaves reversed, a partial one at end of list in order
      if (n >= g || eol) begin
         for (int i = 0; i < n; i++) begin
            r.out_value = (n >= g) ? group_store[n-1-i] : group_store[i];
            r.run_last  = (i == n - 1);
            r.list_done = r.run_last && eol;
            reordered_q.push_back(r);
         end
         fill_level = 0;
      end
   endtask

   task automatic check_result();
      reordered_item_type exp_item;
      if (reordered_q.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual %s%0d %s%0b %s%0b",
                  $time, "out_value=", rsp_out_value, "run_last=", rsp_run_last,
                  "list_done=", rsp_list_done);
         errors++;
      end else begin
         exp_item = reordered_q.pop_front();
         if (rsp_out_value !== exp_item.out_value) begin
            $display("%0t: out_value mismatch: expected %0d, actual %0d",
                     $time, exp_item.out_value, rsp_out_value);
            errors++;
         end
         if (rsp_run_last !== exp_item.run_last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, exp_item.run_last, rsp_run_last);
            errors++;
         end
         if (rsp_list_done !== exp_item.list_done) begin
            $display("%0t: list_done mismatch: expected %0b, actual %0b",
                     $time, exp_item.list_done, rsp_list_done);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         group_size_reg = GROUP_RESET;
         fill_level     = 0;
         errors         = 0;
         reordered_q.delete();
      end else begin
         // results never come in the same cycle as their input: check first
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (csr_write_enable) begin
            group_size_reg = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            reorder_item(req_value, req_end_of_list);
         end
      end
      pending_count <= reordered_q.size();
      fail_count    <= errors;
   end

endmodule : sgr_checker

FILE: sim/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for stream_group_reverser_unit. A directed list set
// covers pass-through, zero and oversize group sizes, reversed full groups,
// in-order partial tails and a group size lowered mid-group; random lists with
// random group sizes follow under three sender/receiver idling mixes. The
// checker beside the block predicts and compares every result.
// -----------------------------------------------------------------------------
module tb_top;
   import sgr_pkg::*;

   localparam int SETTLE_CYCLES = 4;    // block quiet time before a csr write
   localparam int DRAIN_CYCLES  = 40;   // extra time at the end for stray results
   localparam int PHASE_ITEMS   = 90;   // random items per idling phase
   localparam int MAX_LIST_LEN  = 24;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [GROUP_W-1:0]        csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value        = '0;
   logic                      req_end_of_list  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic                      rsp_run_last;
   logic                      rsp_list_done;

   int fail_count;
   int pending_count;
   int send_idle_pct = 20;
   int recv_idle_pct = 74;

   // 20 time unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stream_group_reverser_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_list  (req_end_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_list_done    (rsp_list_done)
   );

   sgr_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_list  (req_end_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_list_done    (rsp_list_done),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Receiver: stall at random, a fresh draw every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Present one item and hold it until the block takes it. Valid stays high
   // on return so back-to-back items need no second assignment in one step.
   task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic eol);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= value;
      req_end_of_list <= eol;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Write group_size only once every predicted result has left the block.
   task automatic set_group_size(input logic [GROUP_W-1:0] size);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
      // let an item that caused no result settle inside the block
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Favor the sign and magnitude extremes now and then.
   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly small groups; the rest cover zero, full depth and saturation.
   function automatic logic [GROUP_W-1:0] pick_group_size();
      if ($urandom_range(0, 3) == 0) begin
         return GROUP_W'($urandom_range(0, 31));
      end
      return GROUP_W'($urandom_range(1, 8));
   endfunction

   // One well-formed list; now and then retune the group size mid-list.
   task automatic send_list(input int len);
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 9) == 0) begin
            set_group_size(pick_group_size());
         end
         send_item(random_value(), i == len - 1);
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      int sent;
      int len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            set_group_size(pick_group_size());
         end
         len = $urandom_range(1, MAX_LIST_LEN);
         send_list(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset group size of one: values pass straight through.
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh8000_0000, 1'b1);

      // Group size zero acts as one.
      set_group_size(GROUP_W'(0));
      send_item(-1, 1'b1);

      // Groups of three: a reversed group, a full group closing the list,
      // then a two-item tail that leaves in arrival order.
      set_group_size(GROUP_W'(3));
      send_item(32'sd1, 1'b0);
      send_item(32'sd2, 1'b0);
      send_item(32'sd3, 1'b0);
      send_item(32'sd4, 1'b0);
      send_item(32'sd5, 1'b0);
      send_item(32'sd6, 1'b1);
      send_item(32'sh7fff_ffff, 1'b0);
      send_item(32'sh8000_0000, 1'b1);

      // Oversize group size saturates; buffer ten items with no result, then
      // lower the size below the fill so the next item flushes all eleven.
      set_group_size(GROUP_W'(31));
      for (int i = 0; i < 10; i++) begin
         send_item(random_value(), 1'b0);
      end
      set_group_size(GROUP_W'(5));
      send_item(32'sh5a5a_a5a5, 1'b1);

      // Random lists under the three idling mixes.
      run_random_phase(20, 74);
      run_random_phase(74, 20);
      run_random_phase(0, 0);

      // Drop valid, wait out the remaining results, then a quiet tail.
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(20 * 400000);
      $display("TB_ERROR");
      $finish;
   end

endmodule : tb_top
